// ===== rtl/core/lla_pkg.sv =====
// Package for the life-like automaton step block.
// Shared widths, command and register codes, defaults and the controller/datapath structs.
// No dependencies.
package lla_pkg;

  // Default grid size
  localparam int ColsDef = 16;
  localparam int RowsDef = 10;

  // Fixed field widths
  localparam int CmdW    = 2;
  localparam int SelW    = 4;
  localparam int DataW   = 16;
  localparam int MaskW   = 9;
  localparam int CntW    = 4;   // neighbor count 0..8
  localparam int CfgIdxW = 2;

  // Commands
  localparam logic [CmdW-1:0] CMD_LOAD = 2'd0;
  localparam logic [CmdW-1:0] CMD_STEP = 2'd1;
  localparam logic [CmdW-1:0] CMD_EMIT = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_BIRTH    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SURVIVAL = 2'd1;

  // Register reset values: B3/S23
  localparam logic [MaskW-1:0] BirthRst    = 9'd8;
  localparam logic [MaskW-1:0] SurvivalRst = 9'd12;

  // Controller to datapath
  typedef struct packed {
    logic start;  // clear window, read row 0
    logic step;   // with start: readout after one generation
    logic fill;   // shift first row into the window, read next
    logic fire;   // produce one row beat, shift, read next
    logic load;   // write one row from the input beat
  } lla_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a beat this cycle
    logic last;      // current row is the bottom row
  } lla_sts_t;

endpackage

// ===== rtl/core/lla_if.sv =====
// Channel interfaces of the life-like automaton step block: input items,
// result rows and register writes. Depends on lla_pkg.
interface lla_in_if import lla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [SelW-1:0]  row_select;
  logic [DataW-1:0] row_data;

  modport source (output valid, command, row_select, row_data, input ready);
  modport sink   (input valid, command, row_select, row_data, output ready);
endinterface

interface lla_out_if import lla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SelW-1:0]  out_row;
  logic [DataW-1:0] out_cells;
  logic             last_row;

  modport source (output valid, out_row, out_cells, last_row, input ready);
  modport sink   (input valid, out_row, out_cells, last_row, output ready);
endinterface

interface lla_cfg_if import lla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [MaskW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/lla_ctrl.sv =====
// Controller of the life-like automaton step block: takes input beats and
// sequences the row sweep of the datapath. Depends on lla_pkg, lla_if.
module lla_ctrl import lla_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  lla_in_if.sink   item_i,
  input  lla_sts_t sts_i,
  output lla_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StFill = 3'b010,
    StRow  = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign item_i.ready = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (item_i.valid) begin
          unique case (item_i.command)
            CMD_LOAD: cmd_o.load = 1'b1;
            CMD_STEP: begin
              cmd_o.start = 1'b1;
              cmd_o.step  = 1'b1;
              state_d     = StFill;
            end
            CMD_EMIT: begin
              cmd_o.start = 1'b1;
              state_d     = StFill;
            end
            default: ;  // unused code: taken and dropped
          endcase
        end
      end
      StFill: begin
        cmd_o.fill = 1'b1;
        state_d    = StRow;
      end
      StRow: begin
        if (sts_i.out_free) begin
          cmd_o.fire = 1'b1;
          if (sts_i.last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/lla_dp.sv =====
// Datapath of the life-like automaton step block: grid memory with row valid
// bits, three-row window, cell rule, masks and output register. Depends on lla_pkg, lla_if.
module lla_dp import lla_pkg::*; #(
  parameter int COLS = ColsDef,
  parameter int ROWS = RowsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lla_cmd_t         cmd_i,
  output lla_sts_t         sts_o,
  input  logic [SelW-1:0]  row_select_i,
  input  logic [DataW-1:0] row_data_i,
  lla_cfg_if.sink          cfg_i,
  lla_out_if.source        result_o
);

  localparam int RowIdxW = $clog2(ROWS);
  localparam int RowCntW = $clog2(ROWS + 2);
  localparam int RowWideW = (COLS > DataW) ? COLS : DataW;
  localparam int IdxWideW = (RowIdxW > SelW) ? RowIdxW : SelW;

  // Registers
  logic [MaskW-1:0] birth_q, survival_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q    <= BirthRst;
      survival_q <= SurvivalRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_BIRTH:    birth_q    <= cfg_i.data;
        CFG_SURVIVAL: survival_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Grid memory; a row that is not valid reads as all dead
  logic [COLS-1:0]    grid_mem [ROWS];
  logic [ROWS-1:0]    row_vld_q;
  logic [COLS-1:0]    rd_data_q;
  logic               rd_vld_q;
  logic [RowCntW-1:0] rd_idx_q, rd_idx_d, rd_addr;
  logic               rd_en, rd_in_range;
  logic               mem_we;
  logic [RowIdxW-1:0] wr_addr;
  logic [COLS-1:0]    wr_data;

  // Window and sweep state
  logic [COLS-1:0]    prev_q, cur_q, fetch, new_row;
  logic [RowIdxW-1:0] out_idx_q;
  logic               step_q;

  // Load path
  logic [IdxWideW-1:0] sel_wide;
  logic [RowWideW-1:0] load_wide;
  logic                sel_in_range;

  assign sel_wide     = IdxWideW'(row_select_i);
  assign load_wide    = RowWideW'(row_data_i);
  assign sel_in_range = (int'(row_select_i) < ROWS);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = out_idx_q;
    wr_data = new_row;
    if (cmd_i.load) begin
      mem_we  = sel_in_range;
      wr_addr = sel_wide[RowIdxW-1:0];
      wr_data = load_wide[COLS-1:0];
    end else if (cmd_i.fire && step_q) begin
      mem_we = 1'b1;
    end
  end

  // Read issue: row 0 on start, then one row ahead of the window per shift
  assign rd_en       = cmd_i.start | cmd_i.fill | cmd_i.fire;
  assign rd_addr     = cmd_i.start ? '0 : rd_idx_q;
  assign rd_idx_d    = rd_addr + RowCntW'(1);
  assign rd_in_range = (rd_addr < RowCntW'(ROWS));

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_mem[wr_addr] <= wr_data;
    if (rd_en && rd_in_range) rd_data_q <= grid_mem[rd_addr[RowIdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      if (mem_we) row_vld_q[wr_addr] <= 1'b1;
      if (rd_en) begin
        rd_vld_q <= rd_in_range && row_vld_q[rd_addr[RowIdxW-1:0]];
        rd_idx_q <= rd_idx_d;
      end
    end
  end

  // Past the bottom edge the fetched row is dead
  assign fetch = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      cur_q     <= '0;
      out_idx_q <= '0;
      step_q    <= 1'b0;
    end else if (cmd_i.start) begin
      prev_q    <= '0;
      cur_q     <= '0;
      out_idx_q <= '0;
      step_q    <= cmd_i.step;
    end else if (cmd_i.fill || cmd_i.fire) begin
      prev_q <= cur_q;
      cur_q  <= fetch;
      if (cmd_i.fire) out_idx_q <= out_idx_q + RowIdxW'(1);
    end
  end

  // Cell rule over the window; MSB is column 0, pads are the dead side edges
  logic [COLS+1:0] pad_p, pad_c, pad_n;
  logic [CntW-1:0] nbr_cnt;

  assign pad_p = {1'b0, prev_q, 1'b0};
  assign pad_c = {1'b0, cur_q, 1'b0};
  assign pad_n = {1'b0, fetch, 1'b0};

  always_comb begin
    new_row = '0;
    nbr_cnt = '0;
    for (int b = 0; b < COLS; b++) begin
      nbr_cnt = CntW'(pad_p[b]) + CntW'(pad_p[b+1]) + CntW'(pad_p[b+2])
              + CntW'(pad_c[b]) + CntW'(pad_c[b+2])
              + CntW'(pad_n[b]) + CntW'(pad_n[b+1]) + CntW'(pad_n[b+2]);
      new_row[b] = cur_q[b] ? survival_q[nbr_cnt] : birth_q[nbr_cnt];
    end
  end

  // Output register
  logic                out_vld_q;
  logic [SelW-1:0]     out_row_q;
  logic [DataW-1:0]    out_cells_q;
  logic                out_last_q;
  logic [RowWideW-1:0] out_wide;
  logic [IdxWideW-1:0] idx_wide;

  assign out_wide = RowWideW'(step_q ? new_row : cur_q);
  assign idx_wide = IdxWideW'(out_idx_q);

  assign sts_o.out_free = !out_vld_q || result_o.ready;
  assign sts_o.last     = (out_idx_q == RowIdxW'(ROWS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.fire) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      out_row_q   <= idx_wide[SelW-1:0];
      out_cells_q <= out_wide[DataW-1:0];
      out_last_q  <= sts_o.last;
    end
  end

  assign result_o.valid     = out_vld_q;
  assign result_o.out_row   = out_row_q;
  assign result_o.out_cells = out_cells_q;
  assign result_o.last_row  = out_last_q;

endmodule

// ===== rtl/core/life_like_automaton_step.sv =====
// Top level of the life-like automaton step block (bounded B/S grid).
// Joins lla_ctrl and lla_dp; depends on lla_pkg and lla_if.
//
//   port      dir   beat carries
//   item_i    in    command, row_select, row_data
//   result_o  out   out_row, out_cells, last_row (one beat per grid row)
//   cfg_i     in    index (0 birth mask, 1 survival mask), data
//
// A load gives no beat. Step and emit read row 0, then prime the window,
// then sweep one grid row per cycle while the result is not stalled,
// through the single read port of the grid memory. A stalled result
// holds the sweep. Reset clears the grid through per-row valid bits, so
// no clearing pass runs.
module life_like_automaton_step import lla_pkg::*; #(
  parameter int COLS = ColsDef,
  parameter int ROWS = RowsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lla_in_if.sink    item_i,
  lla_out_if.source result_o,
  lla_cfg_if.sink   cfg_i
);

  lla_cmd_t cmd;
  lla_sts_t sts;

  lla_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  lla_dp #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .row_select_i (item_i.row_select),
    .row_data_i   (item_i.row_data),
    .cfg_i        (cfg_i),
    .result_o     (result_o)
  );

endmodule
